@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Both expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked only outside reset
`define UF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define UF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UF_ASSERT(lbl, prop, msg)
`define UF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/uf_pkg.sv @@
// ---------------------------------------------------------------------------
// uf_pkg
// Shared sizes, datapath commands and status for the union-find engine.
// ---------------------------------------------------------------------------
package uf_pkg;

  localparam int NODES     = 1024;
  localparam int IDX_W     = $clog2(NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ENTRY_W   = IDX_W + 2;
  localparam int NODE_W    = 10;
  localparam int ROOT_W    = (IDX_W > NODE_W) ? IDX_W : NODE_W;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_FIND  = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_ACCEPT,
    DP_U_LOADA,
    DP_U_WR1,
    DP_U_WR2,
    DP_WALK,
    DP_COMP,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass at its last entry
    logic nodes_ok;   // both request nodes inside the table
    logic walk_more;  // walk takes another hop
    logic walk_self;  // walk ended on the start node
    logic comp_more;  // compression takes another hop
    logic out_busy;   // result register still held
  } status_t;

endpackage

@@ hw/rtl/uf_ram.sv @@
// ---------------------------------------------------------------------------
// uf_ram
// Generic single-write, single-read RAM with registered read, write-first.
// ---------------------------------------------------------------------------
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/uf_dpath.sv @@
// ---------------------------------------------------------------------------
// uf_dpath
// Parent table, walk registers, union arithmetic and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uf_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  uf_pkg::cmd_t                cmd,
  output uf_pkg::status_t             st,
  input  logic [uf_pkg::NODE_W-1:0]   node_a,
  input  logic [uf_pkg::NODE_W-1:0]   node_b,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [uf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import uf_pkg::*;

  localparam logic signed [ENTRY_W:0] SUM_LO = -((ENTRY_W+1)'(NODES));
  localparam logic signed [ENTRY_W:0] SUM_HI = (ENTRY_W+1)'(2 * NODES - 1);

  function automatic entry_t clamp_sum(entry_t a, entry_t b);
    logic signed [ENTRY_W:0] s;
    s = $signed({a[ENTRY_W-1], a}) + $signed({b[ENTRY_W-1], b});
    if (s < SUM_LO) begin
      s = SUM_LO;
    end else if (s > SUM_HI) begin
      s = SUM_HI;
    end
    return s[ENTRY_W-1:0];
  endfunction

  function automatic logic is_link(entry_t e);
    return !e[ENTRY_W-1] && ($unsigned(e) < ENTRY_W'(NODES));
  endfunction

  logic [ROOT_W-1:0]   op_a;
  logic [IDX_W-1:0]    op_b;
  logic [ROOT_W-1:0]   root;
  logic [IDX_W-1:0]    cur;
  logic [CNT_W-1:0]    cnt;
  entry_t              ent_a;
  entry_t              ent_b;
  logic                ge;
  logic                out_valid;
  logic [NODE_W-1:0]   out_node;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [IDX_W-1:0]    raddr;
  logic [ENTRY_W-1:0]  rdata;
  entry_t              ent_rd;
  logic [IDX_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    cnt_inc;
  logic                ge_now;
  logic                rd_link;
  entry_t              sum;

  uf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ent_rd  = entry_t'(rdata);
  assign rd_idx  = rdata[IDX_W-1:0];
  assign cnt_inc = cnt + CNT_W'(1);
  assign ge_now  = (ent_a >= ent_rd);
  assign rd_link = is_link(ent_rd);
  assign sum     = clamp_sum(ent_a, ent_b);

  assign st.clr_last  = (cnt == CNT_W'(NODES - 1));
  assign st.nodes_ok  = (32'(node_a) < NODES) && (32'(node_b) < NODES);
  assign st.walk_more = (cnt < CNT_W'(NODES)) && rd_link;
  assign st.walk_self = (op_a == root);
  assign st.comp_more = rd_link && (cnt_inc < CNT_W'(NODES)) && (ROOT_W'(rd_idx) != root);
  assign st.out_busy  = out_valid && !m_axis_tready;

  // table port selection
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = '1;
    raddr = cur;
    case (cmd.op)
      DP_CLR: begin
        we    = 1'b1;
        waddr = cnt[IDX_W-1:0];
        wdata = '1;
      end
      DP_ACCEPT: begin
        raddr = IDX_W'(node_a);
      end
      DP_U_LOADA: begin
        raddr = op_b;
      end
      DP_U_WR1: begin
        // smaller set goes under the other
        we    = 1'b1;
        waddr = ge_now ? op_a[IDX_W-1:0] : op_b;
        wdata = ge_now ? ENTRY_W'(op_b) : ENTRY_W'(op_a[IDX_W-1:0]);
      end
      DP_U_WR2: begin
        we    = 1'b1;
        waddr = ge ? op_b : op_a[IDX_W-1:0];
        wdata = sum;
      end
      DP_WALK: begin
        raddr = st.walk_more ? rd_idx : op_a[IDX_W-1:0];
      end
      DP_COMP: begin
        we    = 1'b1;
        waddr = cur;
        wdata = ENTRY_W'(root[IDX_W-1:0]);
        raddr = rd_idx;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        DP_CLR: begin
          cnt <= st.clr_last ? '0 : cnt_inc;
        end
        DP_ACCEPT: begin
          cnt <= '0;
        end
        DP_WALK: begin
          cnt <= st.walk_more ? cnt_inc : '0;
        end
        DP_COMP: begin
          cnt <= cnt_inc;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
      if (cmd.op == DP_OUT) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_ACCEPT: begin
        op_a <= ROOT_W'(node_a);
        op_b <= IDX_W'(node_b);
        root <= ROOT_W'(node_a);
      end
      DP_U_LOADA: begin
        ent_a <= ent_rd;
      end
      DP_U_WR1: begin
        ent_b <= ent_rd;
        ge    <= ge_now;
      end
      DP_WALK: begin
        if (st.walk_more) begin
          root <= ROOT_W'(rd_idx);
        end else begin
          cur <= op_a[IDX_W-1:0];
        end
      end
      DP_COMP: begin
        cur <= rd_idx;
      end
      DP_OUT: begin
        out_node <= NODE_W'(root);
      end
      default: begin
        root <= root;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_TDATA_W'(out_node);

  `UF_ASSERT(a_cnt_bound, cnt <= CNT_W'(NODES), "hop counter past table size")
  `UF_ASSERT(a_out_load, (cmd.op == DP_OUT) |=> m_axis_tvalid, "result load lost")

endmodule

@@ hw/rtl/uf_ctrl.sv @@
// ---------------------------------------------------------------------------
// uf_ctrl
// Sequencer: clearing pass, union read/write steps, find walk and compress.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic            mode,
  input  uf_pkg::status_t st,
  output uf_pkg::cmd_t    cmd
);
  import uf_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_UA    = 8'b0000_0100,
    S_UB    = 8'b0000_1000,
    S_UW2   = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_COMP  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    case (state)
      S_CLEAR: begin
        cmd.op = DP_CLR;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.op = DP_ACCEPT;
          if (mode == MODE_FIND) begin
            state_next = st.nodes_ok ? S_WALK : S_OUT;
          end else begin
            state_next = st.nodes_ok ? S_UA : S_IDLE;
          end
        end
      end
      S_UA: begin
        cmd.op     = DP_U_LOADA;
        state_next = S_UB;
      end
      S_UB: begin
        cmd.op     = DP_U_WR1;
        state_next = S_UW2;
      end
      S_UW2: begin
        cmd.op     = DP_U_WR2;
        state_next = S_IDLE;
      end
      S_WALK: begin
        cmd.op = DP_WALK;
        if (!st.walk_more) begin
          state_next = st.walk_self ? S_OUT : S_COMP;
        end
      end
      S_COMP: begin
        cmd.op = DP_COMP;
        if (!st.comp_more) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.op     = DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `UF_ASSERT_ALWAYS(a_rst_clear, rst |=> (state == S_CLEAR), "reset must start clearing pass")
  `UF_ASSERT(a_union_seq, (accept && (mode == MODE_UNION) && st.nodes_ok) |=> (state == S_UA),
             "union request did not start reads")

endmodule

@@ hw/rtl/union_find_engine.sv @@
// ---------------------------------------------------------------------------
// union_find_engine
// Disjoint-set engine: weighted union and find with path compression.
//
//   channel  dir  tdata                                 tuser
//   s_axis   in   node_a [9:0], node_b [19:10], pad     mode (0 union, 1 find)
//   m_axis   out  root_node [9:0], pad                  -
//
// After reset a clearing pass writes -1 to all 1024 table entries, one per
// cycle; no request is taken until the pass is done.
// Union steps: accept, read A, read B + first write, second write.
// Find steps: accept, walk to the root, rewrite the nodes on the path, output;
// one table access per hop on the single read port of the parent table; the
// output step waits while the previous result is still held unaccepted.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
// ---------------------------------------------------------------------------
module union_find_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uf_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // node_a, node_b
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [uf_pkg::M_TDATA_W-1:0]  m_axis_tdata   // root_node
);
  import uf_pkg::*;

  cmd_t              cmd;
  status_t           st;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  assign node_a = s_axis_tdata[NODE_W-1:0];
  assign node_b = s_axis_tdata[2*NODE_W-1:NODE_W];

  uf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .mode         (s_axis_tuser),
    .st           (st),
    .cmd          (cmd)
  );

  uf_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .node_a       (node_a),
    .node_b       (node_b),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

@@ tb/tb_union_find_engine.sv @@
// ----------------------------------------------------------------------------
// tb_union_find_engine
// Stream-level test of the disjoint-set engine. A small forest model mirrors
// the parent table. It predicts the root of every find request and the table
// updates of every union request. Results on the master side are checked in
// order against the predicted roots. Stimulus is a directed opening, then a
// random mix of unions on true roots, finds, and malformed unions. Both sides
// of the stream stall at random, except in the quiet tail of the random mix.
// ----------------------------------------------------------------------------

typedef logic [uf_pkg::NODE_W-1:0] node_t;

class forest_model;
  uf_pkg::entry_t tbl[uf_pkg::NODES];
  node_t          pending_roots[$];

  function new();
    foreach (tbl[k]) tbl[k] = uf_pkg::entry_t'(-1);
  endfunction

  function bit is_link(uf_pkg::entry_t e);
    return (e >= 0) && (e < uf_pkg::NODES);
  endfunction

  // walk to the root without touching the table; bounded for looped chains
  function int root_of(int start);
    int r;
    int hops;
    r = start;
    hops = 0;
    while (hops < uf_pkg::NODES && is_link(tbl[r])) begin
      r = int'(tbl[r]);
      hops++;
    end
    return r;
  endfunction

  function int find_root(int start);
    int r;
    int cur;
    int n;
    uf_pkg::entry_t nxt;
    r = root_of(start);
    cur = start;
    for (n = 0; n < uf_pkg::NODES && cur != r; n++) begin
      nxt = tbl[cur];
      tbl[cur] = uf_pkg::entry_t'(r);
      if (!is_link(nxt)) break;
      cur = int'(nxt);
    end
    return r;
  endfunction

  function void link_sets(int i, int j);
    int a;
    int b;
    int s;
    a = int'(tbl[i]);
    b = int'(tbl[j]);
    s = a + b;
    if (s < -uf_pkg::NODES) s = -uf_pkg::NODES;
    if (s > 2 * uf_pkg::NODES - 1) s = 2 * uf_pkg::NODES - 1;
    // same node twice: the second write wins
    if (a >= b) begin
      tbl[i] = uf_pkg::entry_t'(j);
      tbl[j] = uf_pkg::entry_t'(s);
    end else begin
      tbl[j] = uf_pkg::entry_t'(i);
      tbl[i] = uf_pkg::entry_t'(s);
    end
  endfunction

  function void take_request(logic mode, node_t a, node_t b);
    if (mode == uf_pkg::MODE_UNION) begin
      link_sets(int'(a), int'(b));
    end else begin
      pending_roots.push_back(node_t'(find_root(int'(a))));
    end
  endfunction

  function bit check_root(node_t got, output string why);
    node_t want;
    why = "";
    if (pending_roots.size() == 0) begin
      why = $sformatf("root_node %0d with no find pending", got);
      return 1'b1;
    end
    want = pending_roots.pop_front();
    if (got !== want) begin
      why = $sformatf("root_node %0d, expected %0d", got, want);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function int pending_count();
    return pending_roots.size();
  endfunction
endclass

module tb_union_find_engine;
  import uf_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 500;
  localparam int QUIET_FROM  = 420;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // node_a [9:0], node_b [19:10], pad
  logic                 s_axis_tuser = 1'b0;  // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // root_node [9:0], pad

  forest_model model;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  string       why;

  union_find_engine u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // mostly two small pools at the ends of the table, so sets grow
  function automatic node_t pick_node();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return node_t'($urandom_range(0, 127));
    if (r < 8) return node_t'($urandom_range(896, 1023));
    return node_t'($urandom_range(0, 1023));
  endfunction

  task automatic send_request(input logic mode, input node_t a, input node_t b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(S_TDATA_W - 2 * NODE_W){1'b0}}, b, a};
    do @(posedge clk); while (!s_axis_tready);
    model.take_request(mode, a, b);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (model.check_root(m_axis_tdata[NODE_W-1:0], why)) report_mismatch(why);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_union_find_engine: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    node_t na;
    node_t nb;
    int    ra;
    int    rb;
    int    k;
    int    pick;

    model = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // singletons at both ends, then a plain union across them
    send_request(MODE_FIND, 10'd0, 10'd1023);
    send_request(MODE_FIND, 10'd1023, 10'd0);
    send_request(MODE_UNION, 10'd0, 10'd1023);
    send_request(MODE_FIND, 10'd0, 10'd0);

    // self-union doubles the size until it saturates at -NODES
    for (k = 0; k < 11; k++) send_request(MODE_UNION, 10'd5, 10'd5);
    send_request(MODE_FIND, 10'd5, 10'd1023);

    // links summed past the top of the range; entry beyond the table ends a walk
    send_request(MODE_UNION, 10'd40, 10'd1000);
    send_request(MODE_UNION, 10'd41, 10'd1000);
    send_request(MODE_UNION, 10'd40, 10'd41);
    send_request(MODE_UNION, 10'd41, 10'd41);
    send_request(MODE_FIND, 10'd40, 10'd0);
    send_request(MODE_FIND, 10'd41, 10'd0);

    // build a two-node loop 20 <-> 21, entered from 30
    send_request(MODE_UNION, 10'd30, 10'd23);
    send_request(MODE_UNION, 10'd21, 10'd20);
    send_request(MODE_UNION, 10'd20, 10'd30);
    send_request(MODE_FIND, 10'd30, 10'd0);
    send_request(MODE_FIND, 10'd20, 10'd1023);

    for (k = 0; k < RAND_ITEMS; k++) begin
      quiet = (k >= QUIET_FROM);
      pick = $urandom_range(0, 99);
      na = pick_node();
      nb = pick_node();
      if (pick < 45) begin
        // union on true roots, or a find when that is not possible
        ra = model.root_of(na);
        rb = model.root_of(nb);
        if (ra != rb && model.tbl[ra] < 0 && model.tbl[rb] < 0)
          send_request(MODE_UNION, node_t'(ra), node_t'(rb));
        else
          send_request(MODE_FIND, na, nb);
      end else if (pick < 80) begin
        send_request(MODE_FIND, na, nb);
      end else if (pick < 90) begin
        send_request(MODE_UNION, na, nb);
      end else if (pick < 95) begin
        send_request(MODE_UNION, na, na);
      end else begin
        send_request(MODE_FIND, node_t'($urandom_range(0, 1023)),
                     node_t'($urandom_range(0, 1023)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (model.pending_count() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_union_find_engine: PASS");
    end else begin
      $display("tb_union_find_engine: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/uf_pkg.sv
hw/rtl/uf_ram.sv
hw/rtl/uf_dpath.sv
hw/rtl/uf_ctrl.sv
hw/rtl/union_find_engine.sv
tb/tb_union_find_engine.sv
